@@ src/acl_pkg.sv @@
// shared types and codes for the associative cache with lru / least-used replacement
package acl_pkg;

    // slot index width covers the largest supported table of 256 slots
    localparam int IDX_W = 8;

    typedef logic [IDX_W-1:0] idx_t;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_TOUCH  = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_HIT     = 3'd2;
    localparam logic [2:0] ST_MISS    = 3'd3;
    localparam logic [2:0] ST_REMOVED = 3'd4;

    // replacement policy codes
    localparam logic [1:0] POL_LRU = 2'd0;
    localparam logic [1:0] POL_LFU = 2'd1;

    // slot update operations
    typedef enum logic [1:0] {
        OP_FILL,
        OP_REFRESH,
        OP_BUMP,
        OP_CLEAR
    } cmd_op_t;

    // scan word handed from cell to cell
    typedef struct packed {
        logic        live;
        logic [31:0] key;
        logic        hit;
        idx_t        hit_idx;
        logic        empty;
        idx_t        empty_idx;
        logic        best_set;
        idx_t        best_idx;
        logic [31:0] best_val;
        logic [31:0] best_key;
    } word_t;

    // slot update broadcast to all cells
    typedef struct packed {
        logic        live;
        cmd_op_t     op;
        idx_t        idx;
        logic [31:0] key;
        logic [31:0] stamp;
    } cmd_t;

endpackage

@@ src/assoc_cache_lru_lfu_replace.sv @@
// top level of the fully associative cache with lru / least-used replacement
//
// Requests (req_type, key) are taken at a rising edge with start high and
// busy low. Codes: 0 add, 1 get, 2 touch, 3 remove. One result word per
// request appears on status, slot, evicted, evicted_key and hit_total for
// exactly one cycle, marked by done; the receiver cannot hold it off.
// The slots form a row of ENTRIES cells. A scan word enters the first
// cell after acceptance and moves one cell per cycle, collecting the first
// matching slot, the first empty slot and the replacement victim. When it
// leaves the last cell the sequencer registers the result and broadcasts
// the slot update, which the cells apply at the following edge.
// done rises once the scan word has left the last cell, and busy drops at
// the same edge, so the block takes no new request until the previous one
// has finished; the spacing is set by the length of the cell row.
// The cfg write channel (cfg_valid, cfg_ready, cfg_data) sets the
// replacement policy; cfg_ready is always high and writes belong to idle
// periods. Reset clears every slot, the counters and the policy.
module assoc_cache_lru_lfu_replace
    import acl_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] key,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  slot,
    output logic        evicted,
    output logic [31:0] evicted_key,
    output logic [31:0] hit_total
);

    word_t      chain [ENTRIES+1];
    cmd_t       cmd;
    logic [1:0] policy;

    // sequencer
    acl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .key         (key),
        .busy        (busy),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .policy      (policy),
        .launch      (chain[0]),
        .fin         (chain[ENTRIES]),
        .cmd         (cmd),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .hit_total   (hit_total)
    );

    // row of slot cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        acl_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .policy   (policy),
            .cmd      (cmd),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    // result strobe never overlaps a busy cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // slot updates go out only together with a result
    a_cmd_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.live |-> done)
        else $error("slot update without result");

    // eviction is reported only for an add
    a_evict_add: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> (status == ST_ADDED))
        else $error("eviction reported on a non-add result");

endmodule

@@ src/acl_cell.sv @@
// one cache slot: holds its entry and folds itself into the passing scan word
module acl_cell
    import acl_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] policy,
    input  cmd_t       cmd,
    input  word_t      word_in,
    output word_t      word_out
);

    localparam idx_t MY_IDX = IDX_W'(CELL_IDX);

    logic        valid_reg;
    logic [31:0] key_reg;
    logic [31:0] stamp_reg;
    logic [31:0] uses_reg;
    word_t       word_reg;
    word_t       word_next;
    logic [31:0] val;
    logic        take_best;
    logic        mine;

    assign mine = cmd.live && (cmd.idx == MY_IDX);

    // entry flags and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            stamp_reg <= '0;
            uses_reg  <= '0;
        end
        else if (mine)
        begin
            unique case (cmd.op)
                OP_FILL:
                begin
                    valid_reg <= 1'b1;
                    stamp_reg <= cmd.stamp;
                    uses_reg  <= 32'd1;
                end
                OP_REFRESH:
                begin
                    stamp_reg <= cmd.stamp;
                end
                OP_BUMP:
                begin
                    stamp_reg <= cmd.stamp;
                    uses_reg  <= uses_reg + 32'd1;
                end
                OP_CLEAR:
                begin
                    valid_reg <= 1'b0;
                    stamp_reg <= '0;
                    uses_reg  <= '0;
                end
                default:
                begin
                    valid_reg <= valid_reg;
                end
            endcase
        end
    end

    // entry key, no reset needed
    always_ff @(posedge clk)
    begin
        if (mine && cmd.op == OP_FILL)
            key_reg <= cmd.key;
        else if (mine && cmd.op == OP_CLEAR)
            key_reg <= '0;
    end

    // fold this slot into the scan word
    always_comb
    begin
        val = (policy == POL_LRU) ? stamp_reg : uses_reg;
        if (policy == POL_LRU || policy == POL_LFU)
            take_best = !word_in.best_set || (val < word_in.best_val);
        else
            take_best = !word_in.best_set;

        word_next = word_in;
        if (!word_in.hit && valid_reg && key_reg == word_in.key)
        begin
            word_next.hit     = 1'b1;
            word_next.hit_idx = MY_IDX;
        end
        if (!word_in.empty && !valid_reg)
        begin
            word_next.empty     = 1'b1;
            word_next.empty_idx = MY_IDX;
        end
        if (take_best)
        begin
            word_next.best_set = 1'b1;
            word_next.best_idx = MY_IDX;
            word_next.best_val = val;
            word_next.best_key = key_reg;
        end
    end

    // hand the word to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_in.live ? word_next : '0;
    end

    assign word_out = word_reg;

endmodule

@@ src/acl_ctrl.sv @@
// request sequencer: launches the scan, decides the action, drives the result
module acl_ctrl
    import acl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  req_type,
    input  logic [31:0] key,
    output logic        busy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output logic [1:0]  policy,
    output word_t       launch,
    input  word_t       fin,
    output cmd_t        cmd,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  slot,
    output logic        evicted,
    output logic [31:0] evicted_key,
    output logic [31:0] hit_total
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t      state_reg;
    logic        busy_reg;
    logic [1:0]  policy_reg;
    logic [1:0]  req_reg;
    logic [31:0] now_reg;
    logic [31:0] hits_reg;
    word_t       launch_reg;
    cmd_t        cmd_reg;
    logic        done_reg;
    logic [2:0]  status_reg;
    logic [3:0]  slot_reg;
    logic        evicted_reg;
    logic [31:0] evkey_reg;

    word_t       launch_next;
    cmd_t        cmd_next;
    logic [2:0]  status_next;
    idx_t        slot_idx;
    logic        evicted_next;
    logic [31:0] evkey_next;
    logic        hit_inc;

    assign cfg_ready = 1'b1;

    // policy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= POL_LRU;
        else if (cfg_valid)
            policy_reg <= cfg_data;
    end

    // scan word launched with the accepted request
    always_comb
    begin
        launch_next      = '0;
        launch_next.live = 1'b1;
        launch_next.key  = key;
    end

    // decide the slot update from the finished scan word
    always_comb
    begin
        cmd_next       = '0;
        cmd_next.key   = fin.key;
        cmd_next.stamp = now_reg;
        status_next    = ST_MISS;
        slot_idx       = '0;
        evicted_next   = 1'b0;
        evkey_next     = '0;
        hit_inc        = 1'b0;
        unique case (req_reg)
            REQ_ADD:
            begin
                cmd_next.live = 1'b1;
                if (fin.hit)
                begin
                    cmd_next.op  = OP_REFRESH;
                    cmd_next.idx = fin.hit_idx;
                    status_next  = ST_PRESENT;
                    slot_idx     = fin.hit_idx;
                end
                else
                begin
                    cmd_next.op = OP_FILL;
                    status_next = ST_ADDED;
                    if (fin.empty)
                    begin
                        cmd_next.idx = fin.empty_idx;
                        slot_idx     = fin.empty_idx;
                    end
                    else
                    begin
                        cmd_next.idx = fin.best_idx;
                        slot_idx     = fin.best_idx;
                        evicted_next = 1'b1;
                        evkey_next   = fin.best_key;
                    end
                end
            end
            REQ_GET, REQ_TOUCH:
            begin
                if (fin.hit)
                begin
                    cmd_next.live = 1'b1;
                    cmd_next.op   = OP_BUMP;
                    cmd_next.idx  = fin.hit_idx;
                    status_next   = ST_HIT;
                    slot_idx      = fin.hit_idx;
                    hit_inc       = (req_reg == REQ_GET);
                end
            end
            REQ_REMOVE:
            begin
                if (fin.hit)
                begin
                    cmd_next.live = 1'b1;
                    cmd_next.op   = OP_CLEAR;
                    cmd_next.idx  = fin.hit_idx;
                    status_next   = ST_REMOVED;
                    slot_idx      = fin.hit_idx;
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            now_reg    <= '0;
            hits_reg   <= '0;
            launch_reg <= '0;
            cmd_reg    <= '0;
            done_reg   <= 1'b0;
            req_reg    <= REQ_ADD;
            status_reg <= ST_ADDED;
            slot_reg   <= '0;
            evicted_reg <= 1'b0;
            evkey_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    cmd_reg  <= '0;
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg  <= S_SCAN;
                        busy_reg   <= 1'b1;
                        req_reg    <= req_type;
                        now_reg    <= now_reg + 32'd1;
                        launch_reg <= launch_next;
                    end
                    else
                    begin
                        launch_reg <= '0;
                    end
                end
                S_SCAN:
                begin
                    launch_reg <= '0;
                    if (fin.live)
                    begin
                        state_reg   <= S_IDLE;
                        busy_reg    <= 1'b0;
                        cmd_reg     <= cmd_next;
                        done_reg    <= 1'b1;
                        status_reg  <= status_next;
                        slot_reg    <= slot_idx[3:0];
                        evicted_reg <= evicted_next;
                        evkey_reg   <= evkey_next;
                        if (hit_inc)
                            hits_reg <= hits_reg + 32'd1;
                    end
                    else
                    begin
                        cmd_reg  <= '0;
                        done_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg  <= S_IDLE;
                    launch_reg <= '0;
                    cmd_reg    <= '0;
                    done_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign busy        = busy_reg;
    assign policy      = policy_reg;
    assign launch      = launch_reg;
    assign cmd         = cmd_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evkey_reg;
    assign hit_total   = hits_reg;

endmodule
